FILE: hdl/yuvc_pkg.sv
// ----------------------------------------------------------------------------
// yuvc_pkg
// Shared types and constants for the YUV 4:2:2 to RGB565 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package yuvc_pkg;

  // Byte layouts of the macropixel; the spare code is decoded as YUYV.
  typedef enum logic [1:0] {
    LAYOUT_YUYV = 2'd0,
    LAYOUT_UYVY = 2'd1,
    LAYOUT_YVYU = 2'd2
  } layout_t;

  // Register indexes, taken from paddr[2].
  localparam logic REG_CHROMA_LAYOUT = 1'b0;
  localparam logic REG_COLOR_ORDER   = 1'b1;

  localparam int PaddrWidth = 3;

  // Colour matrix coefficients in units of 1/256.
  localparam logic signed [17:0] CoefRv = 18'sd103;
  localparam logic signed [17:0] CoefGu = 18'sd88;
  localparam logic signed [17:0] CoefGv = 18'sd183;
  localparam logic signed [17:0] CoefBu = 18'sd198;

  localparam logic [7:0] ChromaOffset = 8'd128;

  // Chroma contributions shared by both pixels of a macropixel.
  typedef struct packed {
    logic signed [9:0] r_add;
    logic signed [9:0] g_sub;
    logic signed [9:0] b_add;
  } chroma_t;

endpackage

`default_nettype wire

FILE: hdl/yuvc_chroma.sv
// ----------------------------------------------------------------------------
// yuvc_chroma
// Unpacks a macropixel and forms the chroma terms shared by both pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvc_chroma
  import yuvc_pkg::*;
(
  input  wire logic [7:0] byte_zero,
  input  wire logic [7:0] byte_one,
  input  wire logic [7:0] byte_two,
  input  wire logic [7:0] byte_three,
  input  wire logic [1:0] layout,
  output logic      [7:0] luma_zero,
  output logic      [7:0] luma_one,
  output chroma_t         terms
);

  logic [7:0] cu;
  logic [7:0] cv;
  logic signed [17:0] u_ext;
  logic signed [17:0] v_ext;
  logic signed [17:0] prod_rv;
  logic signed [17:0] prod_gu;
  logic signed [17:0] prod_gv;
  logic signed [17:0] prod_bu;
  logic signed [17:0] sh_rv;
  logic signed [17:0] sh_gu;
  logic signed [17:0] sh_gv;
  logic signed [17:0] sh_bu;

  always_comb begin
    unique case (layout)
      LAYOUT_UYVY: begin
        cu = byte_zero;  luma_zero = byte_one;
        cv = byte_two;   luma_one  = byte_three;
      end
      LAYOUT_YVYU: begin
        luma_zero = byte_zero; cv = byte_one;
        luma_one  = byte_two;  cu = byte_three;
      end
      default: begin
        luma_zero = byte_zero; cu = byte_one;
        luma_one  = byte_two;  cv = byte_three;
      end
    endcase
  end

  // Offset chroma, sign-extended for the products.
  assign u_ext = 18'(signed'({1'b0, cu}) - signed'({1'b0, ChromaOffset}));
  assign v_ext = 18'(signed'({1'b0, cv}) - signed'({1'b0, ChromaOffset}));

  assign prod_rv = v_ext * CoefRv;
  assign prod_gu = u_ext * CoefGu;
  assign prod_gv = v_ext * CoefGv;
  assign prod_bu = u_ext * CoefBu;

  assign sh_rv = prod_rv >>> 8;
  assign sh_gu = prod_gu >>> 8;
  assign sh_gv = prod_gv >>> 8;
  assign sh_bu = prod_bu >>> 8;

  assign terms.r_add = 10'(v_ext + sh_rv);
  assign terms.g_sub = 10'(sh_gu + sh_gv);
  assign terms.b_add = 10'(u_ext + sh_bu);

endmodule

`default_nettype wire

FILE: hdl/yuvc_lane.sv
// ----------------------------------------------------------------------------
// yuvc_lane
// One pixel lane: combines luma with the chroma terms, saturates and packs 565.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvc_lane
  import yuvc_pkg::*;
(
  input  wire logic [7:0]  luma,
  input  wire chroma_t     terms,
  input  wire logic        color_order,
  output logic      [15:0] pixel
);

  logic signed [10:0] sum_r;
  logic signed [10:0] sum_g;
  logic signed [10:0] sum_b;
  logic [7:0] sat_r;
  logic [7:0] sat_g;
  logic [7:0] sat_b;
  logic [7:0] chan_lo;
  logic [7:0] chan_hi;

  function automatic logic [7:0] clamp8(input logic signed [10:0] x);
    logic [7:0] res;
    if (x < 0) begin
      res = 8'd0;
    end else if (x > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  assign sum_r = signed'({3'b000, luma}) + 11'(terms.r_add);
  assign sum_g = signed'({3'b000, luma}) - 11'(terms.g_sub);
  assign sum_b = signed'({3'b000, luma}) + 11'(terms.b_add);

  assign sat_r = clamp8(sum_r);
  assign sat_g = clamp8(sum_g);
  assign sat_b = clamp8(sum_b);

  assign chan_lo = color_order ? sat_b : sat_r;
  assign chan_hi = color_order ? sat_r : sat_b;

  assign pixel = {chan_hi[7:3], sat_g[7:2], chan_lo[7:3]};

endmodule

`default_nettype wire

FILE: hdl/yuv422_to_rgb565_converter.sv
// ----------------------------------------------------------------------------
// yuv422_to_rgb565_converter
// Converts packed YUV 4:2:2 macropixels into pairs of RGB565 pixels.
//
// Input channel: four macropixel bytes and last_in_frame, transferred when
// in_valid and in_ready are both high. Output channel: first_pixel,
// second_pixel and frame_end, transferred when out_valid and out_ready are
// both high. One result is produced for every input transfer.
// The input transfer is captured in the chroma stage register and then in the
// output register, where out_valid rises. Throughput is one macropixel per clock:
// the chroma stage and the two pixel lanes are fully pipelined, so the rate
// is set only by the output register draining.
// When the receiver stalls, the output register holds its result and the
// chroma stage may still take one more transfer before in_ready drops.
// A synchronous reset empties both stages and clears chroma_layout and
// color_order to zero (YUYV, red in the low five bits). The registers are
// written over the APB port and are to be changed only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv422_to_rgb565_converter
  import yuvc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            byte_zero,
  input  wire logic [7:0]            byte_one,
  input  wire logic [7:0]            byte_two,
  input  wire logic [7:0]            byte_three,
  input  wire logic                  last_in_frame,
  // Output channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [15:0]                first_pixel,
  output logic [15:0]                second_pixel,
  output logic                       frame_end,
  // Configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PaddrWidth-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Configuration registers.
  logic [1:0] chroma_layout;
  logic       color_order;
  logic       cfg_write;

  // Chroma stage outputs (combinational) and its pipeline register.
  logic [7:0] luma_zero_c;
  logic [7:0] luma_one_c;
  chroma_t    terms_c;
  logic       s1_valid;
  logic [7:0] s1_luma_zero;
  logic [7:0] s1_luma_one;
  chroma_t    s1_terms;
  logic       s1_last;

  // Lane results feeding the merging output register.
  logic [15:0] lane_pixel_zero;
  logic [15:0] lane_pixel_one;
  logic        out_advance;
  logic        s1_advance;

  // The APB port never inserts wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      chroma_layout <= 2'd0;
      color_order   <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_CHROMA_LAYOUT: chroma_layout <= pwdata[1:0];
        REG_COLOR_ORDER:   color_order   <= pwdata[0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_CHROMA_LAYOUT: prdata = {30'd0, chroma_layout};
      REG_COLOR_ORDER:   prdata = {31'd0, color_order};
      default:           prdata = 32'd0;
    endcase
  end

  // The output register is free when empty or when its result is taken this
  // cycle; the chroma stage can then move forward, and a fresh transfer can
  // enter whenever the chroma stage is empty or moving.
  assign out_advance = !out_valid || out_ready;
  assign s1_advance  = s1_valid && out_advance;
  assign in_ready    = !s1_valid || out_advance;

  yuvc_chroma u_chroma (
    .byte_zero  (byte_zero),
    .byte_one   (byte_one),
    .byte_two   (byte_two),
    .byte_three (byte_three),
    .layout     (chroma_layout),
    .luma_zero  (luma_zero_c),
    .luma_one   (luma_one_c),
    .terms      (terms_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_luma_zero <= luma_zero_c;
      s1_luma_one  <= luma_one_c;
      s1_terms     <= terms_c;
      s1_last      <= last_in_frame;
    end
  end

  // Two lanes, one per luma sample, sharing the chroma terms.
  yuvc_lane u_lane_zero (
    .luma        (s1_luma_zero),
    .terms       (s1_terms),
    .color_order (color_order),
    .pixel       (lane_pixel_zero)
  );

  yuvc_lane u_lane_one (
    .luma        (s1_luma_one),
    .terms       (s1_terms),
    .color_order (color_order),
    .pixel       (lane_pixel_one)
  );

  // Merging stage: both lane results and the frame flag form one result.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      first_pixel  <= lane_pixel_zero;
      second_pixel <= lane_pixel_one;
      frame_end    <= s1_last;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/yuvc_checker.sv
// ----------------------------------------------------------------------------
// yuvc_checker
// Port-level checks for the converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module yuvc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] first_pixel,
  input wire logic [15:0] second_pixel,
  input wire logic        frame_end,
  input wire logic        pready
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  // After an input transfer, out_valid must be high once it has passed the chroma stage and output registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> ##2 out_valid)
    else $error("accepted macropixel did not reach the output");

  // With the output register empty the block must take a transfer.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low while output is empty");

  // A stalled result holds its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(first_pixel) && $stable(second_pixel) && $stable(frame_end)))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind yuv422_to_rgb565_converter yuvc_checker u_yuvc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .first_pixel  (first_pixel),
  .second_pixel (second_pixel),
  .frame_end    (frame_end),
  .pready       (pready)
);

`default_nettype wire
